FILE: sv/rgbxf_pkg.sv
// shared types, constants and colour mapping functions for the rgb group crossfade
package rgbxf_pkg;

  localparam int LVL_W  = 8;
  localparam int DUTY_W = 12;
  localparam int NCOL   = 3;
  localparam int DVD_W  = 11;
  localparam int DVS_W  = 10;

  localparam logic [2:0] OP_SET8    = 3'd0;
  localparam logic [2:0] OP_SET12   = 3'd1;
  localparam logic [2:0] OP_OFF     = 3'd2;
  localparam logic [2:0] OP_FADE    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [DVD_W-1:0] FADE_SPAN = 11'd1020;
  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;
  // 255/4095 as 65296 / 2^20, exact over 0..4095
  localparam logic [16:0]      DN_MUL    = 17'd65296;
  // 1/17 as 241 / 2^12, exact over 0..255
  localparam logic [7:0]       DUTY_MUL  = 8'd241;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef lvl_t [NCOL-1:0]  rgb_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [2:0]        group;
    logic [DUTY_W-1:0] red_in;
    logic [DUTY_W-1:0] green_in;
    logic [DUTY_W-1:0] blue_in;
  } rgbxf_in_t;

  typedef struct packed {
    logic [2:0]        group_out;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
    logic              fade_done;
  } rgbxf_out_t;

  typedef struct packed {
    rgb_t st;
    rgb_t lv;
  } ent_t;

  function automatic lvl_t sat8(input logic [DUTY_W-1:0] v);
    return (v > {4'b0, LEVEL_MAX}) ? LEVEL_MAX : v[LVL_W-1:0];
  endfunction

  // floor(v * 255 / 4095)
  function automatic lvl_t down8(input logic [DUTY_W-1:0] v);
    logic [28:0] p;
    p = {17'b0, v} * {12'b0, DN_MUL};
    return p[27:20];
  endfunction

  // floor(l * 4095 / 255) = 16 l + floor(l / 17)
  function automatic logic [DUTY_W-1:0] to_duty(input lvl_t l);
    logic [15:0] p;
    p = {8'b0, l} * {8'b0, DUTY_MUL};
    return {l, 4'b0} + {8'b0, p[15:12]};
  endfunction

endpackage

FILE: sv/rgbxf_div.sv
// restoring divider, one quotient bit per cycle, shared by the fade step
module rgbxf_div
  import rgbxf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  localparam int IT_W = $clog2(DVD_W + 1);

  logic             run_r;
  logic             done_r;
  logic [IT_W-1:0]  it_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= run_r && !go && (it_r == IT_W'(1));
      if (go) begin
        run_r <= 1'b1;
        it_r  <= IT_W'(DVD_W);
      end else if (run_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == IT_W'(1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

FILE: sv/rgb_group_crossfade.sv
// top level: per-group colour levels and linear crossfade, answered as 12-bit pwm duties
//
//  channel   signals                 handshake
//  -------   ---------------------   ------------------------------------------
//  command   start, busy, in_cmd     beat taken when start is high and busy low
//  result    out_valid, out_res      one beat per command, shown for one cycle
//
//  a command passes through the read, level and write-back states after its
//  acceptance, with the result beat registered from write-back; a fade step
//  adds two passes of the shared 11-step divider per colour whose gap is not zero
//  reset is synchronous and active low; levels read as zero until a group is
//  first written, through per-group valid bits
//  the result side cannot stall; busy holds commands off while one is in work
module rgb_group_crossfade
  import rgbxf_pkg::*;
#(
  parameter int NUM_GROUPS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  rgbxf_in_t  in_cmd,
  output logic       out_valid,
  output rgbxf_out_t out_res
);

  localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_FQ   = 8'b0000_0100,
    S_FQW  = 8'b0000_1000,
    S_FR   = 8'b0001_0000,
    S_FRW  = 8'b0010_0000,
    S_LV   = 8'b0100_0000,
    S_WB   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // group state memory, registered read
  ent_t mem [NUM_GROUPS];
  ent_t rd_r;

  logic [NUM_GROUPS-1:0] vld_r;
  logic [NUM_GROUPS-1:0] done_r;
  logic [DVD_W-1:0]      cnt_r;

  rgbxf_in_t  cmd_r;
  logic       inr_r;
  ent_t       ent_r;
  rgb_t       cvt_r;
  rgb_t       fl_r;
  rgb_t       lv_n_r;
  rgb_t       st_n_r;
  logic [1:0] col_r;
  logic       neg_r;
  logic [DVS_W-1:0] mag_r;
  logic       out_valid_r;
  rgbxf_out_t out_r;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] addr_in;
  logic [AW-1:0] addr_c;
  rgb_t          tgt;
  rgb_t          raw_dn;
  logic [DUTY_W-1:0] raw [NCOL];
  lvl_t          cur_tgt;
  lvl_t          cur_st;
  lvl_t          cur_lv;
  lvl_t          agap;
  logic          gap_zero;
  logic          last_col;
  logic          wrap;
  lvl_t          stepped;

  logic             div_go;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  assign busy     = state_r != S_IDLE;
  assign accept   = start && !busy;
  assign in_range = int'(in_cmd.group) < NUM_GROUPS;
  assign addr_in  = AW'(in_cmd.group);
  assign addr_c   = AW'(cmd_r.group);

  assign raw[0] = cmd_r.red_in;
  assign raw[1] = cmd_r.green_in;
  assign raw[2] = cmd_r.blue_in;

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      tgt[c]    = sat8(raw[c]);
      raw_dn[c] = down8(raw[c]);
    end
  end

  // current colour of the fade sequence
  assign cur_tgt  = tgt[col_r];
  assign cur_st   = ent_r.st[col_r];
  assign cur_lv   = ent_r.lv[col_r];
  assign gap_zero = cur_tgt == cur_st;
  assign agap     = (cur_tgt < cur_st) ? cur_st - cur_tgt : cur_tgt - cur_st;
  assign last_col = col_r == 2'(NCOL - 1);
  assign wrap     = cnt_r >= FADE_SPAN;

  // one step toward the target when the counter is a multiple of the quotient
  always_comb begin
    stepped = cur_lv;
    if (div_rem == '0) begin
      if (neg_r) begin
        stepped = (cur_lv == '0) ? cur_lv : cur_lv - 1'b1;
      end else begin
        stepped = (cur_lv == LEVEL_MAX) ? cur_lv : cur_lv + 1'b1;
      end
    end
  end

  // first pass 1020 / |gap|, second pass counter mod quotient
  assign div_go  = (state_r == S_FQ && !gap_zero) || state_r == S_FR;
  assign div_dvd = (state_r == S_FQ) ? FADE_SPAN : cnt_r;
  assign div_dvs = (state_r == S_FQ) ? {2'b0, agap} : mag_r;

  rgbxf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_RD;
      S_RD: begin
        if (inr_r && cmd_r.opcode == OP_FADE) state_nxt = S_FQ;
        else state_nxt = S_LV;
      end
      S_FQ: begin
        if (!gap_zero) state_nxt = S_FQW;
        else if (last_col) state_nxt = S_LV;
      end
      S_FQW: if (div_done) state_nxt = S_FR;
      S_FR:  state_nxt = S_FRW;
      S_FRW: begin
        if (div_done) state_nxt = last_col ? S_LV : S_FQ;
      end
      S_LV: state_nxt = S_WB;
      S_WB: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      done_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_WB;
      if (state_r == S_WB && inr_r) begin
        vld_r[addr_c] <= 1'b1;
        if (cmd_r.opcode == OP_FADE) begin
          if (wrap) begin
            done_r[addr_c] <= 1'b1;
            cnt_r          <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end else if (cmd_r.opcode == OP_RESTART) begin
          cnt_r <= '0;
        end
      end
    end
  end

  // memory: read at acceptance, write back at the end of the command; the
  // sequencer never reads and writes in the same cycle, so no forwarding
  always_ff @(posedge clk) begin
    if (accept && in_range) rd_r <= mem[addr_in];
    if (state_r == S_WB && inr_r) mem[addr_c] <= '{st: st_n_r, lv: lv_n_r};
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r <= in_cmd;
          inr_r <= in_range;
        end
      end
      S_RD: begin
        ent_r <= (inr_r && vld_r[addr_c]) ? rd_r : '0;
        cvt_r <= raw_dn;
        fl_r  <= '0;
        col_r <= '0;
      end
      S_FQ: begin
        neg_r <= cur_tgt < cur_st;
        if (gap_zero) begin
          fl_r[col_r] <= cur_lv;
          if (!last_col) col_r <= col_r + 1'b1;
        end
      end
      S_FQW: if (div_done) mag_r <= div_quo[DVS_W-1:0];
      S_FRW: begin
        if (div_done) begin
          fl_r[col_r] <= stepped;
          if (!last_col) col_r <= col_r + 1'b1;
        end
      end
      S_LV: begin
        case (cmd_r.opcode)
          OP_SET8: begin
            lv_n_r <= tgt;
            st_n_r <= tgt;
          end
          OP_SET12: begin
            lv_n_r <= cvt_r;
            st_n_r <= cvt_r;
          end
          OP_OFF: begin
            lv_n_r <= '0;
            st_n_r <= '0;
          end
          OP_FADE: begin
            lv_n_r <= fl_r;
            st_n_r <= wrap ? fl_r : ent_r.st;
          end
          OP_RESTART: begin
            lv_n_r <= ent_r.lv;
            st_n_r <= ent_r.lv;
          end
          default: begin
            lv_n_r <= ent_r.lv;
            st_n_r <= ent_r.st;
          end
        endcase
      end
      S_WB: begin
        out_r.group_out <= cmd_r.group;
        if (!inr_r) begin
          out_r.red_duty   <= '0;
          out_r.green_duty <= '0;
          out_r.blue_duty  <= '0;
          out_r.fade_done  <= 1'b0;
        end else begin
          if (cmd_r.opcode == OP_SET12) begin
            out_r.red_duty   <= cmd_r.red_in;
            out_r.green_duty <= cmd_r.green_in;
            out_r.blue_duty  <= cmd_r.blue_in;
          end else begin
            out_r.red_duty   <= to_duty(lv_n_r[0]);
            out_r.green_duty <= to_duty(lv_n_r[1]);
            out_r.blue_duty  <= to_duty(lv_n_r[2]);
          end
          out_r.fade_done <= done_r[addr_c] || (cmd_r.opcode == OP_FADE && wrap);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
